FILE: rtl/fprf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprf_pkg: shared types and constants of the framed packet ring FIFO
// Command and status codes, the queued item format and framing sizes.
// ----------------------------------------------------------------------------
package fprf_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;

  localparam int LEN_BYTES    = 4;
  localparam int STAMP_BYTES  = 8;
  localparam int HEADER_BYTES = LEN_BYTES + STAMP_BYTES;

  localparam int CMD_W    = 2;
  localparam int PLEN_W   = 10;
  localparam int STAMP_W  = 63;
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 11;
  localparam int STATUS_W = 3;
  // Stored length field and header-inclusive total, both fit in 11 bits.
  localparam int FIELD_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_START = 2'd0,
    CMD_WRITE_BYTE  = 2'd1,
    CMD_READ_START  = 2'd2,
    CMD_READ_BYTE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FLUSHED  = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    cmd_t                op;
    logic [PLEN_W-1:0]   plen;
    logic [FIELD_W-1:0]  lenfield;
    logic [FIELD_W-1:0]  total;
    logic [STAMP_W-1:0]  stamp;
    logic [BYTE_W-1:0]   data;
    logic [LIMIT_W-1:0]  limit;
  } item_t;

endpackage

FILE: rtl/fprf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fprf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fprf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprf_front: item intake and classification
// Accepts items, decodes the command and precomputes the header length
// field and total frame size, and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module fprf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fprf_pkg::CMD_W-1:0]      cmd,
  input  logic [fprf_pkg::PLEN_W-1:0]     payload_length,
  input  logic [fprf_pkg::STAMP_W-1:0]    stamp,
  input  logic [fprf_pkg::BYTE_W-1:0]     in_byte,
  input  logic [fprf_pkg::LIMIT_W-1:0]    read_limit,
  output logic                            q_valid,
  output fprf_pkg::item_t                 q_item,
  input  logic                            q_pop
);

  import fprf_pkg::*;

  item_t       q_mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       item_in;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  always_comb begin
    item_in          = '0;
    item_in.op       = cmd_t'(cmd);
    item_in.plen     = payload_length;
    item_in.lenfield = FIELD_W'(payload_length) + FIELD_W'(STAMP_BYTES);
    item_in.total    = FIELD_W'(payload_length) + FIELD_W'(HEADER_BYTES);
    item_in.stamp    = stamp;
    item_in.data     = in_byte;
    item_in.limit    = read_limit;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/fprf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprf_back: ring store sequencer
// Executes queued items against the byte ring, keeps the heads and the
// committed counts, and fills the result register.
// ----------------------------------------------------------------------------
module fprf_back #(
  parameter int BUFFER_BYTES = fprf_pkg::BUFFER_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  fprf_pkg::item_t                       q_item,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [fprf_pkg::STATUS_W-1:0]         status,
  output logic [fprf_pkg::BYTE_W-1:0]           out_byte,
  output logic [fprf_pkg::PLEN_W-1:0]           packet_length,
  output logic                                  last,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]     free_bytes,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]     used_bytes
);

  import fprf_pkg::*;

  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int CW    = $clog2(BUFFER_BYTES + 1);
  localparam int RTW   = FIELD_W + 1;
  localparam int SW    = ((CW > RTW) ? CW : RTW) + 1;
  localparam int HW    = 8 * HEADER_BYTES;
  localparam int NW    = $clog2(HEADER_BYTES);
  localparam int PADW  = 8 * LEN_BYTES - FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WHDR,
    S_RLEN,
    S_RDATA
  } state_t;

  state_t              state, state_next;
  logic [AW-1:0]       write_head, write_head_next;
  logic [AW-1:0]       read_head, read_head_next;
  logic [CW-1:0]       free_cnt, free_cnt_next;
  logic [CW-1:0]       used_cnt, used_cnt_next;
  logic [AW-1:0]       pend_wh, pend_wh_next;
  logic [PLEN_W-1:0]   write_left, write_left_next;
  logic [FIELD_W-1:0]  write_total, write_total_next;
  logic [AW-1:0]       pend_rh, pend_rh_next;
  logic [FIELD_W-1:0]  read_left, read_left_next;
  logic [RTW-1:0]      read_total, read_total_next;
  logic [NW-1:0]       cnt, cnt_next;
  logic [AW-1:0]       walk, walk_next;
  logic [HW-1:0]       hdr, hdr_next;
  logic [FIELD_W-1:0]  len_lo, len_lo_next;
  logic                hi_nz, hi_nz_next;
  item_t               cur, cur_next;

  logic                out_ready;
  logic                emit;
  status_t             res_status;
  logic [BYTE_W-1:0]   res_byte;
  logic [PLEN_W-1:0]   res_plen;
  logic                res_last;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic [RTW-1:0]      rt_sel;
  logic [CW-1:0]       rc_used;
  logic [CW-1:0]       rc_free;
  logic                rc_over;
  logic [FIELD_W-1:0]  wt_sel;
  logic [CW-1:0]       cw_free;
  logic [CW-1:0]       cw_used;
  logic                hi_final;
  logic                len_bad;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    nxt = (p == AW'(BUFFER_BYTES - 1)) ? '0 : p + AW'(1);
  endfunction

  fprf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ready = !out_valid || !out_stall;

  // Read commit. A zero-length frame commits from the length phase with
  // only the length field to release.
  assign rt_sel  = (state == S_RLEN) ? RTW'(LEN_BYTES) : read_total;
  assign rc_used = (SW'(used_cnt) >= SW'(rt_sel)) ?
                   CW'(SW'(used_cnt) - SW'(rt_sel)) : '0;
  assign rc_free = CW'(SW'(free_cnt) + SW'(rt_sel));
  assign rc_over = (SW'(free_cnt) > SW'(BUFFER_BYTES)) ||
                   (SW'(free_cnt) + SW'(rt_sel) > SW'(BUFFER_BYTES));

  assign wt_sel  = (state == S_WHDR) ? cur.total : write_total;
  assign cw_free = (SW'(free_cnt) >= SW'(wt_sel)) ?
                   CW'(SW'(free_cnt) - SW'(wt_sel)) : '0;
  assign cw_used = CW'(SW'(used_cnt) + SW'(wt_sel));

  // The top length byte arrives on the cycle of the check itself.
  assign hi_final = hi_nz || (|ram_rdata);
  assign len_bad  = hi_final || (len_lo > cur.limit) ||
                    (SW'(len_lo) + SW'(LEN_BYTES) > SW'(used_cnt));

  always_comb begin
    state_next       = state;
    write_head_next  = write_head;
    read_head_next   = read_head;
    free_cnt_next    = free_cnt;
    used_cnt_next    = used_cnt;
    pend_wh_next     = pend_wh;
    write_left_next  = write_left;
    write_total_next = write_total;
    pend_rh_next     = pend_rh;
    read_left_next   = read_left;
    read_total_next  = read_total;
    cnt_next         = cnt;
    walk_next        = walk;
    hdr_next         = hdr;
    len_lo_next      = len_lo;
    hi_nz_next       = hi_nz;
    cur_next         = cur;
    q_pop            = 1'b0;
    emit             = 1'b0;
    res_status       = ST_OK;
    res_byte         = '0;
    res_plen         = '0;
    res_last         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = pend_wh;
    ram_wdata        = cur.data;
    ram_re           = 1'b0;
    ram_raddr        = walk;

    case (state)
      S_IDLE: begin
        if (q_valid && out_ready) begin
          q_pop    = 1'b1;
          cur_next = q_item;
          case (q_item.op)
            CMD_WRITE_START: begin
              write_left_next = '0;
              if (SW'(free_cnt) < SW'(q_item.total)) begin
                emit       = 1'b1;
                res_status = ST_NO_SPACE;
              end else begin
                hdr_next   = {1'b0, q_item.stamp, PADW'(0), q_item.lenfield};
                walk_next  = write_head;
                cnt_next   = '0;
                state_next = S_WHDR;
              end
            end
            CMD_WRITE_BYTE: begin
              emit = 1'b1;
              if (write_left == '0) begin
                res_status = ST_IGNORED;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = pend_wh;
                ram_wdata       = q_item.data;
                pend_wh_next    = nxt(pend_wh);
                write_left_next = write_left - PLEN_W'(1);
                if (write_left == PLEN_W'(1)) begin
                  write_head_next = nxt(pend_wh);
                  free_cnt_next   = cw_free;
                  used_cnt_next   = cw_used;
                  res_last        = 1'b1;
                end
              end
            end
            CMD_READ_START: begin
              read_left_next = '0;
              if (used_cnt == '0) begin
                emit       = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = read_head;
                walk_next  = nxt(read_head);
                cnt_next   = NW'(1);
                state_next = S_RLEN;
              end
            end
            CMD_READ_BYTE: begin
              if (read_left == '0) begin
                emit       = 1'b1;
                res_status = ST_IGNORED;
              end else begin
                ram_re         = 1'b1;
                ram_raddr      = pend_rh;
                pend_rh_next   = nxt(pend_rh);
                read_left_next = read_left - FIELD_W'(1);
                state_next     = S_RDATA;
              end
            end
            default: begin
              emit       = 1'b1;
              res_status = ST_IGNORED;
            end
          endcase
        end
      end

      S_WHDR: begin
        if ((cnt != NW'(HEADER_BYTES - 1)) || out_ready) begin
          ram_we    = 1'b1;
          ram_waddr = walk;
          ram_wdata = hdr[BYTE_W-1:0];
          hdr_next  = hdr >> BYTE_W;
          walk_next = nxt(walk);
          cnt_next  = cnt + NW'(1);
          if (cnt == NW'(HEADER_BYTES - 1)) begin
            emit             = 1'b1;
            pend_wh_next     = nxt(walk);
            write_left_next  = cur.plen;
            write_total_next = cur.total;
            state_next       = S_IDLE;
            if (cur.plen == '0) begin
              write_head_next = nxt(walk);
              free_cnt_next   = cw_free;
              used_cnt_next   = cw_used;
              res_last        = 1'b1;
            end
          end
        end
      end

      S_RLEN: begin
        // cnt counts length bytes requested; the data register holds byte cnt-1.
        if ((cnt != NW'(LEN_BYTES)) || out_ready) begin
          cnt_next = cnt + NW'(1);
          if (cnt != NW'(LEN_BYTES)) begin
            ram_re    = 1'b1;
            ram_raddr = walk;
            walk_next = nxt(walk);
          end
          if (cnt == NW'(1)) begin
            len_lo_next = FIELD_W'(ram_rdata);
            hi_nz_next  = 1'b0;
          end else if (cnt == NW'(2)) begin
            len_lo_next = {ram_rdata[FIELD_W-9:0], len_lo[7:0]};
            hi_nz_next  = |ram_rdata[7:FIELD_W-8];
          end else if (cnt == NW'(3)) begin
            hi_nz_next = hi_nz || (|ram_rdata);
          end else begin
            emit       = 1'b1;
            state_next = S_IDLE;
            if (len_bad) begin
              read_head_next = write_head;
              free_cnt_next  = CW'(BUFFER_BYTES);
              used_cnt_next  = '0;
              read_left_next = '0;
              res_status     = ST_FLUSHED;
            end else begin
              pend_rh_next    = walk;
              read_left_next  = len_lo;
              read_total_next = RTW'(len_lo) + RTW'(LEN_BYTES);
              res_plen        = len_lo[PLEN_W-1:0];
              if (len_lo == '0) begin
                res_last = 1'b1;
                if (rc_over) begin
                  read_head_next = write_head;
                  free_cnt_next  = CW'(BUFFER_BYTES);
                  used_cnt_next  = '0;
                  read_left_next = '0;
                  res_status     = ST_FLUSHED;
                end else begin
                  read_head_next = walk;
                  used_cnt_next  = rc_used;
                  free_cnt_next  = rc_free;
                end
              end
            end
          end
        end
      end

      S_RDATA: begin
        if (out_ready) begin
          emit       = 1'b1;
          res_byte   = ram_rdata;
          state_next = S_IDLE;
          if (read_left == '0) begin
            res_last = 1'b1;
            if (rc_over) begin
              read_head_next = write_head;
              free_cnt_next  = CW'(BUFFER_BYTES);
              used_cnt_next  = '0;
              res_status     = ST_FLUSHED;
            end else begin
              read_head_next = pend_rh;
              used_cnt_next  = rc_used;
              free_cnt_next  = rc_free;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hdr    <= hdr_next;
    walk   <= walk_next;
    len_lo <= len_lo_next;
    hi_nz  <= hi_nz_next;
    cur    <= cur_next;
    if (emit) begin
      status        <= res_status;
      out_byte      <= res_byte;
      packet_length <= res_plen;
      last          <= res_last;
      free_bytes    <= free_cnt_next;
      used_bytes    <= used_cnt_next;
    end
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      write_head  <= '0;
      read_head   <= '0;
      free_cnt    <= CW'(BUFFER_BYTES);
      used_cnt    <= '0;
      pend_wh     <= '0;
      write_left  <= '0;
      write_total <= '0;
      pend_rh     <= '0;
      read_left   <= '0;
      read_total  <= '0;
      cnt         <= '0;
    end else begin
      state       <= state_next;
      out_valid   <= emit || (out_valid && out_stall);
      write_head  <= write_head_next;
      read_head   <= read_head_next;
      free_cnt    <= free_cnt_next;
      used_cnt    <= used_cnt_next;
      pend_wh     <= pend_wh_next;
      write_left  <= write_left_next;
      write_total <= write_total_next;
      pend_rh     <= pend_rh_next;
      read_left   <= read_left_next;
      read_total  <= read_total_next;
      cnt         <= cnt_next;
    end
  end

endmodule

FILE: rtl/framed_packet_ring_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_ring_fifo_top: framed packet ring FIFO
// Byte ring that stores length- and timestamp-framed packets.
// ----------------------------------------------------------------------------
// Each packet sits in the ring as a 4-byte little-endian length (payload + 8),
// an 8-byte timestamp and the payload; every item gives exactly one result.
// Items are decoded into a two-entry queue and then executed by a sequencer
// around a single ring RAM with one write and one registered read port, so
// the cost of an item is set by its RAM accesses: write_byte makes one byte
// write, read_byte one registered read, write_start twelve header byte writes
// and read_start four length byte reads; rejected or stray items make no RAM
// access. A result waits in the output register while the queue keeps taking
// items until both entries are full. The ring contents are not cleared at
// reset and need no clearing pass; the heads and counts come up empty at once.
module framed_packet_ring_fifo_top #(
  parameter int BUFFER_BYTES = fprf_pkg::BUFFER_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [fprf_pkg::CMD_W-1:0]            cmd,
  input  logic [fprf_pkg::PLEN_W-1:0]           payload_length,
  input  logic [fprf_pkg::STAMP_W-1:0]          stamp,
  input  logic [fprf_pkg::BYTE_W-1:0]           in_byte,
  input  logic [fprf_pkg::LIMIT_W-1:0]          read_limit,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [fprf_pkg::STATUS_W-1:0]         status,
  output logic [fprf_pkg::BYTE_W-1:0]           out_byte,
  output logic [fprf_pkg::PLEN_W-1:0]           packet_length,
  output logic                                  last,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]     free_bytes,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]     used_bytes
);

  import fprf_pkg::*;

  logic   q_valid;
  item_t  q_item;
  logic   q_pop;

  fprf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .payload_length (payload_length),
    .stamp          (stamp),
    .in_byte        (in_byte),
    .read_limit     (read_limit),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  fprf_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_byte      (out_byte),
    .packet_length (packet_length),
    .last          (last),
    .free_bytes    (free_bytes),
    .used_bytes    (used_bytes)
  );

endmodule
